// ===== hw/rtl/flow_tracking_table_core_macros.svh =====
// Assertion macros for the flow tracking table checker.
`ifndef FLOW_TRACKING_TABLE_CORE_MACROS_SVH
`define FLOW_TRACKING_TABLE_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define FTT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked on every clock edge outside reset.
`define FTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== hw/rtl/ftt_pkg.sv =====
// Package with types, codes and constants of the flow tracking table.
`timescale 1ns / 1ps
package ftt_pkg;
   localparam int FLOW_SLOTS = 256;
   localparam int SLOT_BITS = $clog2(FLOW_SLOTS);
   localparam int CNT_BITS = SLOT_BITS + 1;

   localparam logic [1:0] KIND_PACKET = 2'd0;
   localparam logic [1:0] KIND_RTT = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;
   localparam logic [1:0] KIND_SWEEP = 2'd3;

   localparam logic [2:0] ST_HIT = 3'd0;
   localparam logic [2:0] ST_CREATED = 3'd1;
   localparam logic [2:0] ST_INVALID = 3'd2;
   localparam logic [2:0] ST_FULL = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;
   localparam logic [2:0] ST_REMOVED = 3'd5;
   localparam logic [2:0] ST_SWEEP_DONE = 3'd6;

   localparam logic [1:0] REG_MAX_FLOWS = 2'd0;
   localparam logic [1:0] REG_TIMEOUT = 2'd1;
   localparam logic [1:0] REG_MODE = 2'd2;

   localparam logic [7:0] PROTO_UDP = 8'd17;
   localparam logic [15:0] MIN_LENGTH = 16'd28;
   localparam logic [3:0] IP_V4 = 4'd4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  ip_ver;
      logic [7:0]  protocol;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [15:0] length;
      logic [31:0] rtt_us;
      logic [31:0] now_sec;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  slot;
      logic [1:0]  flow_mode;
      logic [31:0] packet_count;
      logic [47:0] byte_count;
      logic [31:0] rtt_current;
      logic [31:0] rtt_min;
      logic [31:0] rtt_max;
      logic [31:0] rtt_average;
      logic [8:0]  removed_count;
      logic [8:0]  active_flows;
   } rsp_type;

   // One table entry as held in memory.
   typedef struct packed {
      logic [63:0] addresses;
      logic [31:0] ports;
      logic [1:0]  mode;
      logic [31:0] last_seen;
      logic [31:0] packets;
      logic [47:0] bytes;
      logic [31:0] rtt_now;
      logic [31:0] rtt_low;
      logic [31:0] rtt_high;
      logic [31:0] rtt_mean;
   } entry_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic                 load;
      logic                 rd_en;
      logic [SLOT_BITS-1:0] rd_addr;
      logic                 hold_hit;
      logic                 wr_entry;
      logic                 learn;
      logic                 clear_valid;
      logic                 sweep_check;
      logic                 finish;
      logic [2:0]           status;
      logic                 emit_flow;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic                 invalid;
      logic                 match;
      logic                 idle;
      logic                 slot_valid;
      logic                 can_learn;
      logic [1:0]           kind;
   } stat_type;
endpackage

// ===== hw/rtl/ftt_datapath.sv =====
// Datapath of the flow tracking table: entry memory, valid bits, counters, result.
`timescale 1ns / 1ps
module ftt_datapath import ftt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_in,
   input  cmd_type     cmd,
   input  logic [8:0]  flow_limit,
   input  logic [11:0] timeout,
   input  logic [1:0]  default_mode,
   output stat_type    stat,
   output logic        rsp_strobe,
   output rsp_type     rsp_data
);
   entry_type mem [FLOW_SLOTS];
   entry_type rd_ff;
   logic [SLOT_BITS-1:0] rd_addr_ff, rd_addr_in;
   logic [FLOW_SLOTS-1:0] valid_ff;
   logic [CNT_BITS-1:0] count_ff, count_in, removed_ff, removed_in;
   req_type req_ff;
   logic [SLOT_BITS-1:0] hit_ff;
   logic rv_ff;
   logic strobe_ff;
   rsp_type rsp_ff, rsp_in;
   logic [63:0] key_addr;
   logic [31:0] key_ports;
   entry_type wr_val;
   logic [34:0] avg_sum;
   logic [31:0] age;

   assign key_addr = {req_ff.src_ip, req_ff.dst_ip};
   assign key_ports = (req_ff.protocol == PROTO_UDP) ? {req_ff.sport, req_ff.dport}
                                                     : 32'd0;
   assign rd_addr_in = cmd.rd_addr;

   // Entry memory with registered read.
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_ff <= mem[cmd.rd_addr];
      end
      if (cmd.wr_entry) begin
         mem[hit_ff] <= wr_val;
      end
   end

   // Item capture and read address tracking.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_in;
      end
      if (cmd.rd_en) begin
         rd_addr_ff <= rd_addr_in;
         rv_ff <= valid_ff[cmd.rd_addr];
      end
      if (cmd.hold_hit) begin
         hit_ff <= rd_addr_ff;
      end
   end

   // Status toward the controller.
   assign age = req_ff.now_sec - rd_ff.last_seen;
   always_comb begin
      stat.kind = req_ff.kind;
      stat.invalid = (req_ff.length < MIN_LENGTH) || (req_ff.ip_ver != IP_V4) ||
                     (req_ff.src_ip == 32'd0) || (req_ff.dst_ip == 32'd0);
      stat.slot_valid = rv_ff;
      stat.match = rv_ff && (rd_ff.addresses == key_addr) && (rd_ff.ports == key_ports);
      stat.idle = rv_ff && (req_ff.now_sec >= rd_ff.last_seen) &&
                  (age > {20'd0, timeout});
      stat.can_learn = ({{(9-CNT_BITS+1){1'b0}}, count_ff[CNT_BITS-2:0]} < flow_limit) &&
                       !count_ff[CNT_BITS-1];
   end

   // Updated entry for packet and rtt items.
   always_comb begin
      wr_val = rd_ff;
      avg_sum = {3'd0, rd_ff.rtt_mean} * 35'd7 + {3'd0, req_ff.rtt_us};
      if (cmd.learn) begin
         wr_val.addresses = key_addr;
         wr_val.ports = key_ports;
         wr_val.mode = default_mode;
         wr_val.packets = 32'd0;
         wr_val.bytes = 48'd0;
         wr_val.rtt_now = 32'd0;
         wr_val.rtt_low = 32'd0;
         wr_val.rtt_high = 32'd0;
         wr_val.rtt_mean = 32'd0;
      end
      if (req_ff.kind == KIND_PACKET) begin
         wr_val.packets = wr_val.packets + 32'd1;
         wr_val.bytes = wr_val.bytes + {32'd0, req_ff.length};
         wr_val.last_seen = req_ff.now_sec;
      end else begin
         wr_val.rtt_now = req_ff.rtt_us;
         if (rd_ff.rtt_low == 32'd0 || req_ff.rtt_us < rd_ff.rtt_low) begin
            wr_val.rtt_low = req_ff.rtt_us;
         end
         if (req_ff.rtt_us > rd_ff.rtt_high) begin
            wr_val.rtt_high = req_ff.rtt_us;
         end
         wr_val.rtt_mean = (rd_ff.rtt_mean == 32'd0) ? req_ff.rtt_us : avg_sum[34:3];
      end
   end

   // Valid bits, flow count and sweep tally.
   always_comb begin
      count_in = count_ff;
      removed_in = removed_ff;
      if (cmd.learn) begin
         count_in = count_ff + 1'b1;
      end
      if ((cmd.clear_valid || (cmd.sweep_check && stat.idle)) && count_ff != '0) begin
         count_in = count_ff - 1'b1;
      end
      if (cmd.load) begin
         removed_in = '0;
      end else if (cmd.sweep_check && stat.idle) begin
         removed_in = removed_ff + 1'b1;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         removed_ff <= '0;
      end else begin
         count_ff <= count_in;
         removed_ff <= removed_in;
         if (cmd.learn) begin
            valid_ff[hit_ff] <= 1'b1;
         end
         if (cmd.clear_valid) begin
            valid_ff[hit_ff] <= 1'b0;
         end
         if (cmd.sweep_check && stat.idle) begin
            valid_ff[rd_addr_ff] <= 1'b0;
         end
      end
   end

   // Next result beat.
   always_comb begin
      rsp_in = '0;
      rsp_in.status = cmd.status;
      rsp_in.active_flows = 9'(count_in);
      if (cmd.status == ST_SWEEP_DONE) begin
         rsp_in.removed_count = 9'(removed_ff);
      end
      if (cmd.emit_flow) begin
         rsp_in.slot = 8'(hit_ff);
         rsp_in.flow_mode = cmd.wr_entry ? wr_val.mode : rd_ff.mode;
         rsp_in.packet_count = cmd.wr_entry ? wr_val.packets : rd_ff.packets;
         rsp_in.byte_count = cmd.wr_entry ? wr_val.bytes : rd_ff.bytes;
         rsp_in.rtt_current = cmd.wr_entry ? wr_val.rtt_now : rd_ff.rtt_now;
         rsp_in.rtt_min = cmd.wr_entry ? wr_val.rtt_low : rd_ff.rtt_low;
         rsp_in.rtt_max = cmd.wr_entry ? wr_val.rtt_high : rd_ff.rtt_high;
         rsp_in.rtt_average = cmd.wr_entry ? wr_val.rtt_mean : rd_ff.rtt_mean;
      end
   end

   // Result register, one beat per item.
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.finish;
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end
   assign rsp_strobe = strobe_ff;
   assign rsp_data = rsp_ff;
endmodule

// ===== hw/rtl/ftt_controller.sv =====
// Controller of the flow tracking table: sequences the lookup, free-slot and sweep scans.
`timescale 1ns / 1ps
module ftt_controller import ftt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output logic     busy,
   output cmd_type  cmd
);
   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_LOOK, S_FREE, S_APPLY, S_SWEEP, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic busy_ff, busy_in;
   logic learn_ff, learn_in;
   logic last;

   assign last = (idx_ff[SLOT_BITS-1:0] == SLOT_BITS'(FLOW_SLOTS - 1));

   // Next state, scan index and commands.
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      busy_in = busy_ff;
      learn_in = learn_ff;
      cmd = '0;
      cmd.rd_addr = idx_ff[SLOT_BITS-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               busy_in = 1'b1;
               learn_in = 1'b0;
               idx_in = '0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.kind == KIND_PACKET && stat.invalid) begin
               cmd.finish = 1'b1;
               cmd.status = ST_INVALID;
               state_in = S_DONE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in = (stat.kind == KIND_SWEEP) ? S_SWEEP : S_LOOK;
            end
         end
         S_LOOK: begin
            // Data of the slot read last cycle is in.
            if (stat.match) begin
               cmd.hold_hit = 1'b1;
               state_in = S_APPLY;
            end else if (!last) begin
               idx_in = idx_ff + 1'b1;
               cmd.rd_addr = idx_in[SLOT_BITS-1:0];
               cmd.rd_en = 1'b1;
            end else if (stat.kind == KIND_PACKET && stat.can_learn) begin
               idx_in = '0;
               cmd.rd_addr = '0;
               cmd.rd_en = 1'b1;
               state_in = S_FREE;
            end else begin
               cmd.finish = 1'b1;
               cmd.status = (stat.kind == KIND_PACKET) ? ST_FULL : ST_NOT_FOUND;
               state_in = S_DONE;
            end
         end
         S_FREE: begin
            if (!stat.slot_valid) begin
               cmd.hold_hit = 1'b1;
               learn_in = 1'b1;
               state_in = S_APPLY;
            end else if (!last) begin
               idx_in = idx_ff + 1'b1;
               cmd.rd_addr = idx_in[SLOT_BITS-1:0];
               cmd.rd_en = 1'b1;
            end else begin
               cmd.finish = 1'b1;
               cmd.status = ST_FULL;
               state_in = S_DONE;
            end
         end
         S_APPLY: begin
            cmd.finish = 1'b1;
            cmd.emit_flow = 1'b1;
            cmd.learn = learn_ff;
            unique case (stat.kind)
               KIND_PACKET: begin
                  cmd.wr_entry = 1'b1;
                  cmd.status = learn_ff ? ST_CREATED : ST_HIT;
               end
               KIND_RTT: begin
                  cmd.wr_entry = 1'b1;
                  cmd.status = ST_HIT;
               end
               default: begin
                  cmd.clear_valid = 1'b1;
                  cmd.status = ST_REMOVED;
               end
            endcase
            state_in = S_DONE;
         end
         S_SWEEP: begin
            cmd.sweep_check = 1'b1;
            if (!last) begin
               idx_in = idx_ff + 1'b1;
               cmd.rd_addr = idx_in[SLOT_BITS-1:0];
               cmd.rd_en = 1'b1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.kind == KIND_SWEEP && !learn_ff) begin
               // Tally is complete in the cycle after the last check.
               cmd.finish = 1'b1;
               cmd.status = ST_SWEEP_DONE;
               learn_in = 1'b1;
            end else begin
               busy_in = 1'b0;
               learn_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
         busy_ff <= 1'b0;
         learn_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         busy_ff <= busy_in;
         learn_ff <= learn_in;
      end
   end
   assign busy = busy_ff;
endmodule

// ===== hw/rtl/flow_tracking_table_core.sv =====
// Top level of the flow tracking table: register port, controller and datapath.
// One item at a time: start is taken while busy is low, and exactly one result
// beat follows on rsp_strobe for one cycle in the last busy cycle; the receiver
// cannot stall it. An invalid packet finishes without a scan. Any other item
// reads the slots in order from slot 0: a lookup stops at the first matching
// slot, and when a packet misses and may learn, a second scan looks for the
// lowest free slot; a sweep checks every slot. Busy stays high through these
// scans, and the next item is taken once busy is low. The scan length is set by
// the one-slot-a-cycle read port of the entry memory.
`timescale 1ns / 1ps
module flow_tracking_table_core import ftt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   logic [8:0] max_ff;
   logic [11:0] timeout_ff;
   logic [1:0] mode_ff;
   logic [1:0] reg_idx;
   cmd_type cmd;
   stat_type stat;
   logic accept;

   assign pready = 1'b1;
   assign reg_idx = paddr[3:2];
   assign accept = start && !busy;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= 9'd256;
         timeout_ff <= 12'd300;
         mode_ff <= 2'd0;
      end else if (psel && penable && pwrite) begin
         unique case (reg_idx)
            REG_MAX_FLOWS: max_ff <= pwdata[8:0];
            REG_TIMEOUT: timeout_ff <= pwdata[11:0];
            REG_MODE: mode_ff <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   // Register read back.
   always_comb begin
      unique case (reg_idx)
         REG_MAX_FLOWS: prdata = {23'd0, max_ff};
         REG_TIMEOUT: prdata = {20'd0, timeout_ff};
         REG_MODE: prdata = {30'd0, mode_ff};
         default: prdata = 32'd0;
      endcase
   end

   ftt_controller u_ctrl (
      .clock(clock), .reset(reset), .start(accept), .stat(stat), .busy(busy), .cmd(cmd)
   );

   ftt_datapath u_dp (
      .clock(clock), .reset(reset), .req_in(req_data), .cmd(cmd), .flow_limit(max_ff),
      .timeout(timeout_ff), .default_mode(mode_ff), .stat(stat),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );
endmodule

// ===== hw/rtl/ftt_checker.sv =====
// Port-level checker for the flow tracking table, bound to the top level.
`timescale 1ns / 1ps
`include "flow_tracking_table_core_macros.svh"
module ftt_checker import ftt_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);
   // An accepted item makes the block busy.
   `FTT_ASSERT_NEXT(a_busy_after_start, clock, reset, start && !busy, busy)
   // Results appear only while an item is in work.
   `FTT_ASSERT_IMP(a_strobe_busy, clock, reset, rsp_strobe, busy)
   // Only one result beat per item.
   `FTT_ASSERT_NEXT(a_single_beat, clock, reset, rsp_strobe, !rsp_strobe)
   // Removed counts show only on sweep results.
   `FTT_ASSERT_IMP(a_removed_sweep, clock, reset,
      rsp_strobe && rsp_data.status != ST_SWEEP_DONE, rsp_data.removed_count == 9'd0)
endmodule

bind flow_tracking_table_core ftt_checker u_ftt_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
);

// ===== verif/flow_tracking_table_core_checker.sv =====
// Checker for the flow tracking table: predicts each result beat and compares it.
`timescale 1ns / 1ps
module flow_tracking_table_core_checker import ftt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  req_type     req_data,
   input  logic        rsp_strobe,
   input  rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          pending_count
);
   // Shadow copy of the table and its registers.
   logic             tbl_valid [FLOW_SLOTS];
   entry_type        tbl_entry [FLOW_SLOTS];
   logic [8:0]       tbl_active;
   logic [8:0]       lim_flows;
   logic [11:0]      lim_timeout;
   logic [1:0]       learn_mode;
   rsp_type          pending_rsp [$];

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic int lookup_slot(input logic [63:0] addr, input logic [31:0] ports);
      for (int i = 0; i < FLOW_SLOTS; i++)
         if (tbl_valid[i] && tbl_entry[i].addresses == addr && tbl_entry[i].ports == ports)
            return i;
      return -1;
   endfunction

   function automatic void fill_flow(inout rsp_type r, input int s);
      r.slot = s[7:0];
      r.flow_mode = tbl_entry[s].mode;
      r.packet_count = tbl_entry[s].packets;
      r.byte_count = tbl_entry[s].bytes;
      r.rtt_current = tbl_entry[s].rtt_now;
      r.rtt_min = tbl_entry[s].rtt_low;
      r.rtt_max = tbl_entry[s].rtt_high;
      r.rtt_average = tbl_entry[s].rtt_mean;
   endfunction

   // Apply one accepted item to the shadow table and return its result.
   function automatic rsp_type predict_flow_result(input req_type q);
      rsp_type     r;
      logic [63:0] addr;
      logic [31:0] ports;
      logic [34:0] avg;
      logic [8:0]  gone;
      int          s;
      r = '0;
      addr = {q.src_ip, q.dst_ip};
      ports = (q.protocol == PROTO_UDP) ? {q.sport, q.dport} : 32'd0;
      case (q.kind)
         KIND_PACKET: begin
            if (q.length < MIN_LENGTH || q.ip_ver != IP_V4 || q.src_ip == 0 ||
                q.dst_ip == 0) begin
               r.status = ST_INVALID;
            end else begin
               s = lookup_slot(addr, ports);
               r.status = ST_HIT;
               if (s < 0) begin
                  if (tbl_active < lim_flows)
                     for (int i = 0; i < FLOW_SLOTS; i++)
                        if (!tbl_valid[i]) begin
                           s = i;
                           break;
                        end
                  if (s >= 0) begin
                     tbl_valid[s] = 1'b1;
                     tbl_entry[s] = '0;
                     tbl_entry[s].addresses = addr;
                     tbl_entry[s].ports = ports;
                     tbl_entry[s].mode = learn_mode;
                     tbl_active++;
                     r.status = ST_CREATED;
                  end else begin
                     r.status = ST_FULL;
                  end
               end
               if (s >= 0) begin
                  tbl_entry[s].packets = tbl_entry[s].packets + 32'd1;
                  tbl_entry[s].bytes = tbl_entry[s].bytes + {32'd0, q.length};
                  tbl_entry[s].last_seen = q.now_sec;
                  fill_flow(r, s);
               end
            end
         end
         KIND_RTT: begin
            s = lookup_slot(addr, ports);
            if (s < 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               tbl_entry[s].rtt_now = q.rtt_us;
               if (tbl_entry[s].rtt_low == 0 || q.rtt_us < tbl_entry[s].rtt_low)
                  tbl_entry[s].rtt_low = q.rtt_us;
               if (q.rtt_us > tbl_entry[s].rtt_high) tbl_entry[s].rtt_high = q.rtt_us;
               if (tbl_entry[s].rtt_mean == 0) begin
                  tbl_entry[s].rtt_mean = q.rtt_us;
               end else begin
                  avg = (35'(tbl_entry[s].rtt_mean) * 35'd7 + 35'(q.rtt_us)) >> 3;
                  tbl_entry[s].rtt_mean = avg[31:0];
               end
               r.status = ST_HIT;
               fill_flow(r, s);
            end
         end
         KIND_REMOVE: begin
            s = lookup_slot(addr, ports);
            if (s < 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               fill_flow(r, s);
               tbl_valid[s] = 1'b0;
               if (tbl_active > 0) tbl_active--;
               r.status = ST_REMOVED;
            end
         end
         default: begin
            gone = '0;
            for (int i = 0; i < FLOW_SLOTS; i++)
               if (tbl_valid[i] && q.now_sec >= tbl_entry[i].last_seen &&
                   q.now_sec - tbl_entry[i].last_seen > 32'(lim_timeout)) begin
                  tbl_valid[i] = 1'b0;
                  if (tbl_active > 0) tbl_active--;
                  gone++;
               end
            r.status = ST_SWEEP_DONE;
            r.removed_count = gone;
         end
      endcase
      r.active_flows = tbl_active;
      return r;
   endfunction

   // Watch the register port, the input beats and the result beats.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < FLOW_SLOTS; i++) tbl_valid[i] = 1'b0;
         tbl_active = '0;
         lim_flows = 9'd256;
         lim_timeout = 12'd300;
         learn_mode = 2'd0;
         pending_rsp.delete();
      end else begin
         if (psel && penable && pwrite && pready)
            case (paddr[3:2])
               REG_MAX_FLOWS: lim_flows = pwdata[8:0];
               REG_TIMEOUT: lim_timeout = pwdata[11:0];
               REG_MODE: learn_mode = pwdata[1:0];
               default: ;
            endcase
         if (rsp_strobe) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch("unexpected result beat", 64'(rsp_data.status), 64'd0);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
               if (rsp_data.slot !== want.slot)
                  report_mismatch("slot", 64'(rsp_data.slot), 64'(want.slot));
               if (rsp_data.flow_mode !== want.flow_mode)
                  report_mismatch("flow_mode", 64'(rsp_data.flow_mode),
                                  64'(want.flow_mode));
               if (rsp_data.packet_count !== want.packet_count)
                  report_mismatch("packet_count", 64'(rsp_data.packet_count),
                                  64'(want.packet_count));
               if (rsp_data.byte_count !== want.byte_count)
                  report_mismatch("byte_count", 64'(rsp_data.byte_count),
                                  64'(want.byte_count));
               if (rsp_data.rtt_current !== want.rtt_current)
                  report_mismatch("rtt_current", 64'(rsp_data.rtt_current),
                                  64'(want.rtt_current));
               if (rsp_data.rtt_min !== want.rtt_min)
                  report_mismatch("rtt_min", 64'(rsp_data.rtt_min), 64'(want.rtt_min));
               if (rsp_data.rtt_max !== want.rtt_max)
                  report_mismatch("rtt_max", 64'(rsp_data.rtt_max), 64'(want.rtt_max));
               if (rsp_data.rtt_average !== want.rtt_average)
                  report_mismatch("rtt_average", 64'(rsp_data.rtt_average),
                                  64'(want.rtt_average));
               if (rsp_data.removed_count !== want.removed_count)
                  report_mismatch("removed_count", 64'(rsp_data.removed_count),
                                  64'(want.removed_count));
               if (rsp_data.active_flows !== want.active_flows)
                  report_mismatch("active_flows", 64'(rsp_data.active_flows),
                                  64'(want.active_flows));
            end
         end
         if (start && !busy)
            pending_rsp.insert(pending_rsp.size(), predict_flow_result(req_data));
      end
      pending_count = pending_rsp.size();
   end
endmodule

// ===== verif/flow_tracking_table_core_tb.sv =====
// Testbench top for the flow tracking table: stimulus, register setup and verdict.
`timescale 1ns / 1ps
module flow_tracking_table_core_tb;
   import ftt_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count;
   int          pending_count;
   int          idle_cycles = 0;
   int          items_sent = 0;
   int          sweeps_sent = 0;
   logic [31:0] clock_sec = 32'd1000;

   // Small pool of flow keys so lookups hit, learn and fill the table.
   logic [31:0] pool_src [16];
   logic [31:0] pool_dst [16];
   logic [15:0] pool_sp [16];
   logic [15:0] pool_dp [16];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   flow_tracking_table_core dut (.*);

   flow_tracking_table_core_checker checker_i (.*);

   // Watchdog on cycles with no beat on either channel.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Send one input beat after a random gap.
   task automatic send_item(input req_type q);
      int gap;
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) @(posedge clock);
      start <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (busy) @(posedge clock);
      start <= 1'b0;
      items_sent++;
      if (q.kind == KIND_SWEEP) sweeps_sent++;
   endtask

   task automatic drain_results();
      while (pending_count != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   function automatic req_type pool_item(input logic [1:0] kind);
      req_type q;
      int      k;
      k = $urandom_range(0, 15);
      q = '0;
      q.kind = kind;
      q.ip_ver = IP_V4;
      q.protocol = ($urandom_range(0, 4) == 0) ? 8'($urandom) : PROTO_UDP;
      q.src_ip = pool_src[k];
      q.dst_ip = pool_dst[k];
      q.sport = pool_sp[k];
      q.dport = pool_dp[k];
      q.length = 16'($urandom_range(28, 1500));
      q.rtt_us = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 5000);
      q.now_sec = clock_sec;
      return q;
   endfunction

   function automatic req_type noise_item();
      req_type      q;
      logic [191:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      q = raw[$bits(req_type)-1:0];
      if ($urandom_range(0, 1)) q.ip_ver = IP_V4;
      if ($urandom_range(0, 3) == 0) q.src_ip = 0;
      if ($urandom_range(0, 3) == 0) q.length = 16'($urandom_range(0, 27));
      return q;
   endfunction

   initial begin
      req_type q;
      for (int i = 0; i < 16; i++) begin
         pool_src[i] = $urandom | 32'h1;
         pool_dst[i] = $urandom | 32'h100;
         pool_sp[i] = 16'($urandom);
         pool_dp[i] = 16'($urandom);
      end
      pool_src[0] = 32'hFFFF_FFFF;
      pool_dst[0] = 32'hFFFF_FFFF;
      pool_sp[0] = 16'hFFFF;
      pool_dp[0] = 16'hFFFF;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: validity corners, learning, RTT, removal, table full, sweep.
      q = pool_item(KIND_PACKET);
      q.length = 16'd27;
      send_item(q);
      q.length = 16'hFFFF;
      q.ip_ver = 4'd6;
      send_item(q);
      q.ip_ver = IP_V4;
      q.dst_ip = 0;
      send_item(q);
      q = pool_item(KIND_PACKET);
      q.length = 16'd28;
      send_item(q);
      q.length = 16'hFFFF;
      send_item(q);
      q.kind = KIND_RTT;
      q.rtt_us = 32'hFFFF_FFFF;
      send_item(q);
      q.rtt_us = 32'd1;
      send_item(q);
      q.rtt_us = 32'd0;
      send_item(q);
      q.kind = KIND_REMOVE;
      send_item(q);
      send_item(q);
      q.kind = KIND_RTT;
      send_item(q);
      drain_results();
      write_reg(REG_MAX_FLOWS, 32'd1);
      write_reg(REG_MODE, 32'd3);
      write_reg(REG_TIMEOUT, 32'd10);
      for (int i = 0; i < 3; i++) send_item(pool_item(KIND_PACKET));
      q = pool_item(KIND_SWEEP);
      q.now_sec = 32'd0;
      send_item(q);
      q.now_sec = clock_sec + 32'd11;
      send_item(q);
      drain_results();
      write_reg(REG_MAX_FLOWS, 32'd0);
      send_item(pool_item(KIND_PACKET));
      drain_results();

      // Random phases over several register settings.
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: write_reg(REG_MAX_FLOWS, 32'd256);
            1: write_reg(REG_MAX_FLOWS, 32'd4);
            2: write_reg(REG_TIMEOUT, 32'd3600);
            3: write_reg(REG_MODE, 32'd1);
            4: write_reg(REG_MAX_FLOWS, 32'($urandom_range(1, 256)));
            5: write_reg(REG_TIMEOUT, 32'($urandom_range(10, 3600)));
            default: write_reg(REG_MODE, 32'd2);
         endcase
         for (int n = 0; n < 100; n++) begin
            clock_sec = clock_sec + $urandom_range(0, 40);
            case ($urandom_range(0, 19))
               0, 1: send_item(noise_item());
               2: send_item(pool_item(KIND_SWEEP));
               3, 4: send_item(pool_item(KIND_REMOVE));
               5, 6, 7, 8: send_item(pool_item(KIND_RTT));
               default: send_item(pool_item(KIND_PACKET));
            endcase
         end
         drain_results();
      end

      $display("Sent %0d items, %0d of them sweeps, over several register settings.",
               items_sent, sweeps_sent);
      if (fail_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule
